@@ rtl/core/chp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// chp_pkg: shared types and constants for the corner-pin homography unit
// Item layouts, status codes, register indexes and internal datapath widths.
// ----------------------------------------------------------------------------
package chp_pkg;

  localparam int CW      = 32;            // coordinate and coefficient width
  localparam int EW      = 16;            // tolerance register width
  localparam int CFG_IW  = 2;             // register index width
  localparam int FRAC    = 16;            // Q16.16 fraction bits
  localparam int QONE    = 65536;         // 1.0 in Q16.16

  localparam int DFW     = CW + 1;        // corner difference
  localparam int D3W     = CW + 2;        // second difference
  localparam int SPW     = 2 * CW;        // shoelace product
  localparam int SHW     = SPW + 1;       // shoelace term
  localparam int SW      = SPW + 3;       // shoelace sum
  localparam int XPW     = 2 * DFW;       // corner cross product term
  localparam int XW      = XPW + 1;       // corner cross product
  localparam int DW      = XW;            // denominator
  localparam int GPW     = D3W + DFW;     // g/h numerator term
  localparam int GW      = GPW + 1;       // g/h numerator
  localparam int LOW     = 34;            // split point for wide operands
  localparam int NW      = DFW + DW + 1;  // divider numerator
  localparam int QW      = CW;            // quotient bits per division

  localparam int NUM_DIV = 6;
  localparam int DIV_LAT = QW + 3;        // divider register depth

  // divider lanes
  localparam int DIV_G = 0;
  localparam int DIV_H = 1;
  localparam int DIV_A = 2;
  localparam int DIV_B = 3;
  localparam int DIV_D = 4;
  localparam int DIV_E = 5;

  // identity corners, one bit per coordinate: set means 1.0, clear means 0
  localparam logic [7:0] IDENT_ONE = 8'b1011_0100;

  localparam logic [CFG_IW-1:0] CFG_IDENTITY_EPS   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_DEGENERATE_EPS = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_SINGULAR_EPS   = 2'd2;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [NW-1:0] num_t;
  typedef logic signed [DW-1:0] den_t;

  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_IDENT    = 2'd1,
    ST_DEGEN    = 2'd2,
    ST_SINGULAR = 2'd3
  } status_t;

  typedef struct packed {
    coord_t corner0_x;
    coord_t corner0_y;
    coord_t corner1_x;
    coord_t corner1_y;
    coord_t corner2_x;
    coord_t corner2_y;
    coord_t corner3_x;
    coord_t corner3_y;
  } quad_t;

  typedef struct packed {
    coord_t      coef_a;
    coord_t      coef_b;
    coord_t      coef_c;
    coord_t      coef_d;
    coord_t      coef_e;
    coord_t      coef_f;
    coord_t      coef_g;
    coord_t      coef_h;
    logic [1:0]  status;
  } map_t;

  typedef struct packed {
    logic [EW-1:0] identity_eps;
    logic [EW-1:0] degenerate_eps;
    logic [EW-1:0] singular_eps;
  } cfg_t;

  // per-item results that bypass the dividers
  typedef struct packed {
    status_t status;
    logic    affine;
    coord_t  a;
    coord_t  b;
    coord_t  c;
    coord_t  d;
    coord_t  e;
    coord_t  f;
  } side_t;

endpackage
`default_nettype wire

@@ rtl/core/chp_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// chp_front: classification and numerator pipeline
// Six stages: differences, products, cross terms, sums and partial products,
// status, final numerators for the six dividers.
// ----------------------------------------------------------------------------
module chp_front (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    in_vld,
  input  chp_pkg::quad_t                          quad,
  input  chp_pkg::cfg_t                           cfg,
  output logic                                    out_vld,
  output chp_pkg::side_t                          side,
  output chp_pkg::num_t [chp_pkg::NUM_DIV-1:0]    num,
  output chp_pkg::den_t                           den
);
  import chp_pkg::*;

  typedef logic signed [DFW-1:0] dif_t;
  typedef logic signed [D3W-1:0] d3_t;

  localparam dif_t ONE_D = DFW'(QONE);

  function automatic coord_t sat_dif(input dif_t v);
    if (v[DFW-1] != v[DFW-2]) begin
      sat_dif = v[DFW-1] ? COORD_MIN : COORD_MAX;
    end else begin
      sat_dif = v[CW-1:0];
    end
  endfunction

  logic v1, v2, v3, v4, v5, v6;

  // stage 1 ------------------------------------------------------------------
  coord_t pc [8];
  dif_t   idf [8];
  dif_t   ieps;
  logic   ident_c;

  always_comb begin
    pc[0] = quad.corner0_x;
    pc[1] = quad.corner0_y;
    pc[2] = quad.corner1_x;
    pc[3] = quad.corner1_y;
    pc[4] = quad.corner2_x;
    pc[5] = quad.corner2_y;
    pc[6] = quad.corner3_x;
    pc[7] = quad.corner3_y;
    ieps    = $signed(DFW'(cfg.identity_eps));
    ident_c = 1'b1;
    for (int i = 0; i < 8; i++) begin
      idf[i] = DFW'(pc[i]) - (IDENT_ONE[i] ? ONE_D : dif_t'(0));
      if ((idf[i] > ieps) || (idf[i] < -ieps)) begin
        ident_c = 1'b0;
      end
    end
  end

  coord_t s1_px [4];
  coord_t s1_py [4];
  dif_t   s1_ex [4];
  dif_t   s1_ey [4];
  dif_t   s1_dx1, s1_dx2, s1_dy1, s1_dy2;
  d3_t    s1_dx3, s1_dy3;
  dif_t   s1_db, s1_de;
  logic   s1_ident;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s1_px[i] <= pc[2*i];
        s1_py[i] <= pc[2*i+1];
        s1_ex[i] <= DFW'(pc[2*((i+1)%4)]) - DFW'(pc[2*i]);
        s1_ey[i] <= DFW'(pc[2*((i+1)%4)+1]) - DFW'(pc[2*i+1]);
      end
      s1_dx1   <= DFW'(pc[2]) - DFW'(pc[4]);
      s1_dx2   <= DFW'(pc[6]) - DFW'(pc[4]);
      s1_dy1   <= DFW'(pc[3]) - DFW'(pc[5]);
      s1_dy2   <= DFW'(pc[7]) - DFW'(pc[5]);
      s1_dx3   <= D3W'(pc[0]) - D3W'(pc[2]) + D3W'(pc[4]) - D3W'(pc[6]);
      s1_dy3   <= D3W'(pc[1]) - D3W'(pc[3]) + D3W'(pc[5]) - D3W'(pc[7]);
      s1_db    <= DFW'(pc[6]) - DFW'(pc[0]);
      s1_de    <= DFW'(pc[7]) - DFW'(pc[1]);
      s1_ident <= ident_c;
    end
  end

  // stage 2: products ----------------------------------------------------------
  logic signed [SPW-1:0] s2_sa [4];
  logic signed [SPW-1:0] s2_sb [4];
  logic signed [XPW-1:0] s2_xa [4];
  logic signed [XPW-1:0] s2_xb [4];
  logic signed [XPW-1:0] s2_dna, s2_dnb;
  logic signed [GPW-1:0] s2_nga, s2_ngb, s2_nha, s2_nhb;
  dif_t                  s2_dn [4];
  coord_t                s2_pm [4];
  logic                  s2_ident, s2_zero;
  side_t                 s2_side;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s2_sa[i] <= s1_px[i] * s1_py[(i+1)%4];
        s2_sb[i] <= s1_px[(i+1)%4] * s1_py[i];
        s2_xa[i] <= s1_ex[i] * s1_ey[(i+1)%4];
        s2_xb[i] <= s1_ey[i] * s1_ex[(i+1)%4];
      end
      s2_dna <= s1_dx1 * s1_dy2;
      s2_dnb <= s1_dx2 * s1_dy1;
      s2_nga <= s1_dx3 * s1_dy2;
      s2_ngb <= s1_dx2 * s1_dy3;
      s2_nha <= s1_dx1 * s1_dy3;
      s2_nhb <= s1_dx3 * s1_dy1;
      s2_dn[0] <= s1_ex[0];
      s2_dn[1] <= s1_db;
      s2_dn[2] <= s1_ey[0];
      s2_dn[3] <= s1_de;
      s2_pm[0] <= s1_px[1];
      s2_pm[1] <= s1_px[3];
      s2_pm[2] <= s1_py[1];
      s2_pm[3] <= s1_py[3];
      s2_ident <= s1_ident;
      s2_zero  <= (s1_dx3 == '0) && (s1_dy3 == '0);
      s2_side.status <= ST_OK;
      s2_side.affine <= 1'b0;
      s2_side.a      <= sat_dif(s1_ex[0]);
      s2_side.b      <= sat_dif(s1_ex[1]);
      s2_side.c      <= s1_px[0];
      s2_side.d      <= sat_dif(s1_ey[0]);
      s2_side.e      <= sat_dif(s1_ey[1]);
      s2_side.f      <= s1_py[0];
    end
  end

  // stage 3: differences of products -------------------------------------------
  logic signed [SHW-1:0] s3_sh [4];
  logic signed [XW-1:0]  s3_cr [4];
  den_t                  s3_den;
  logic signed [GW-1:0]  s3_ng, s3_nh;
  dif_t                  s3_dn [4];
  coord_t                s3_pm [4];
  logic                  s3_ident, s3_zero;
  side_t                 s3_side;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s3_sh[i] <= SHW'(s2_sa[i]) - SHW'(s2_sb[i]);
        s3_cr[i] <= XW'(s2_xa[i]) - XW'(s2_xb[i]);
        s3_dn[i] <= s2_dn[i];
        s3_pm[i] <= s2_pm[i];
      end
      s3_den   <= DW'(s2_dna) - DW'(s2_dnb);
      s3_ng    <= GW'(s2_nga) - GW'(s2_ngb);
      s3_nh    <= GW'(s2_nha) - GW'(s2_nhb);
      s3_ident <= s2_ident;
      s3_zero  <= s2_zero;
      s3_side  <= s2_side;
    end
  end

  // stage 4: shoelace sum, corner tests, numerator partial products -----------
  logic signed [XW-1:0] xeps;
  den_t                 seps;
  logic                 xbad_c, sing_c, seen, sneg;
  logic signed [GW-1:0] gs [4];

  always_comb begin
    xeps   = $signed(XW'(cfg.degenerate_eps));
    seps   = $signed(DW'(cfg.singular_eps));
    xbad_c = 1'b0;
    seen   = 1'b0;
    sneg   = 1'b0;
    // signs must agree once the first nonzero one is seen
    for (int i = 0; i < 4; i++) begin
      if ((s3_cr[i] < xeps) && (s3_cr[i] > -xeps)) begin
        xbad_c = 1'b1;
      end
      if (!seen) begin
        if (s3_cr[i] != '0) begin
          seen = 1'b1;
          sneg = s3_cr[i][XW-1];
        end
      end else if ((s3_cr[i] == '0) || (s3_cr[i][XW-1] != sneg)) begin
        xbad_c = 1'b1;
      end
    end
    sing_c = (s3_den == '0) || ((s3_den < seps) && (s3_den > -seps));
    gs[0] = s3_ng;
    gs[1] = s3_nh;
    gs[2] = s3_ng;
    gs[3] = s3_nh;
  end

  logic signed [SW-1:0]          s4_s;
  logic                          s4_xbad, s4_sing, s4_ident, s4_zero;
  logic signed [DFW+LOW:0]       s4_dl [4];
  logic signed [DFW+DW-LOW-1:0]  s4_dh [4];
  logic signed [CW+LOW:0]        s4_gl [4];
  logic signed [CW+GW-LOW-1:0]   s4_gh [4];
  den_t                          s4_den;
  num_t                          s4_gnum, s4_hnum;
  side_t                         s4_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_s <= SW'(s3_sh[0]) + SW'(s3_sh[1]) + SW'(s3_sh[2]) + SW'(s3_sh[3]);
      for (int j = 0; j < 4; j++) begin
        s4_dl[j] <= s3_dn[j] * $signed({1'b0, s3_den[LOW-1:0]});
        s4_dh[j] <= s3_dn[j] * $signed(s3_den[DW-1:LOW]);
        s4_gl[j] <= s3_pm[j] * $signed({1'b0, gs[j][LOW-1:0]});
        s4_gh[j] <= s3_pm[j] * $signed(gs[j][GW-1:LOW]);
      end
      s4_xbad  <= xbad_c;
      s4_sing  <= sing_c;
      s4_ident <= s3_ident;
      s4_zero  <= s3_zero;
      s4_den   <= s3_den;
      s4_gnum  <= NW'(s3_ng) <<< FRAC;
      s4_hnum  <= NW'(s3_nh) <<< FRAC;
      s4_side  <= s3_side;
    end
  end

  // stage 5: status, numerator halves ------------------------------------------
  logic signed [SW-1:0] deps2;
  logic                 aff_c;
  status_t              status_c;
  side_t                side_c;

  always_comb begin
    deps2 = $signed(SW'({cfg.degenerate_eps, 1'b0}));
    aff_c = s4_zero && (cfg.singular_eps != '0);
    if (s4_ident) begin
      status_c = ST_IDENT;
    end else if (((s4_s < deps2) && (s4_s > -deps2)) || s4_xbad) begin
      status_c = ST_DEGEN;
    end else if (aff_c) begin
      status_c = ST_OK;
    end else if (s4_sing) begin
      status_c = ST_SINGULAR;
    end else begin
      status_c = ST_OK;
    end
    side_c        = s4_side;
    side_c.status = status_c;
    side_c.affine = aff_c;
  end

  num_t  s5_t1 [4];
  num_t  s5_t2 [4];
  den_t  s5_den;
  num_t  s5_gnum, s5_hnum;
  side_t s5_side;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        s5_t1[j] <= (NW'(s4_dh[j]) <<< LOW) + NW'(s4_dl[j]);
        s5_t2[j] <= (NW'(s4_gh[j]) <<< LOW) + NW'(s4_gl[j]);
      end
      s5_den  <= s4_den;
      s5_gnum <= s4_gnum;
      s5_hnum <= s4_hnum;
      s5_side <= side_c;
    end
  end

  // stage 6: final numerators ------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      num[DIV_G] <= s5_gnum;
      num[DIV_H] <= s5_hnum;
      for (int j = 0; j < 4; j++) begin
        num[DIV_A+j] <= s5_t1[j] + s5_t2[j];
      end
      den  <= s5_den;
      side <= s5_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  assign out_vld = v6;

endmodule
`default_nettype wire

@@ rtl/core/chp_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// chp_divider: pipelined signed divider, rounded and saturated to Q16.16
// Magnitudes, overflow test, one restoring quotient bit per stage, rounding.
// ----------------------------------------------------------------------------
module chp_divider (
  input  logic            clk,
  input  logic            en,
  input  chp_pkg::num_t   num,
  input  chp_pkg::den_t   den,
  output chp_pkg::coord_t quo
);
  import chp_pkg::*;

  localparam logic [QW:0] HALF = (QW+1)'(1) << (QW - 1);

  logic [NW-1:0] a_n;
  logic [DW-1:0] a_d;
  logic          a_neg;

  logic [DW-1:0] rem  [QW+1];
  logic [QW-1:0] lq   [QW+1];   // numerator bits out on the left, quotient in
  logic [DW-1:0] dv   [QW+1];
  logic          neg  [QW+1];
  logic          over [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      a_n     <= num[NW-1] ? $unsigned(-num) : $unsigned(num);
      a_d     <= den[DW-1] ? $unsigned(-den) : $unsigned(den);
      a_neg   <= num[NW-1] ^ den[DW-1];
      // quotient of 2^QW or more saturates whatever the rounding
      over[0] <= a_n >= NW'({a_d, {QW{1'b0}}});
      rem[0]  <= a_n[QW +: DW];
      lq[0]   <= a_n[QW-1:0];
      dv[0]   <= a_d;
      neg[0]  <= a_neg;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        take;

    assign trial = {rem[k], lq[k][QW-1]};
    assign diff  = trial - {1'b0, dv[k]};
    assign take  = trial >= {1'b0, dv[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? diff[DW-1:0] : trial[DW-1:0];
        lq[k+1]   <= {lq[k][QW-2:0], take};
        dv[k+1]   <= dv[k];
        neg[k+1]  <= neg[k];
        over[k+1] <= over[k];
      end
    end
  end

  logic        rnd;
  logic [QW:0] qr;
  coord_t      qs;

  assign rnd = {rem[QW], 1'b0} >= {1'b0, dv[QW]};
  assign qr  = {1'b0, lq[QW]} + (QW+1)'(rnd);

  always_comb begin
    if (over[QW]) begin
      qs = neg[QW] ? COORD_MIN : COORD_MAX;
    end else if (neg[QW]) begin
      qs = (qr > HALF) ? COORD_MIN : CW'(-qr);
    end else begin
      qs = (qr > (HALF - (QW+1)'(1))) ? COORD_MAX : qr[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= qs;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/corner_pin_homography_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// corner_pin_homography_unit: unit-square to quad projective map
// Classifies a quad of Q16.16 corners and computes the eight coefficients of
// the square-to-quad homography, with a status code.
// ----------------------------------------------------------------------------
// Fully pipelined: one item accepted per cycle unless the output stalls; the
// result passes 6 front stages for differences, products, convexity and
// numerators, 35 stages in each of six parallel dividers that produce one
// quotient bit per stage, and the output register. The whole pipeline
// advances together; it holds only while a result sits in the output
// register and map_ready is low, so quad_ready follows that condition.
// Rejected quads (identity, non-convex or degenerate, singular) give
// all-zero coefficients. Tolerance registers are written through the cfg
// port at any time (cfg_ready is always high); indexes beyond 2 are dropped.
module corner_pin_homography_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         quad_valid,
  output logic                         quad_ready,
  input  chp_pkg::quad_t               quad,
  output logic                         map_valid,
  input  logic                         map_ready,
  output chp_pkg::map_t                map,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [chp_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [chp_pkg::EW-1:0]       cfg_data
);
  import chp_pkg::*;

  // global advance: stall only when a finished item is not taken
  logic en;
  assign en         = !map_valid || map_ready;
  assign quad_ready = en;
  assign cfg_ready  = 1'b1;

  // tolerance registers
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.identity_eps   <= EW'(1);
      cfg.degenerate_eps <= EW'(4);
      cfg.singular_eps   <= EW'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDENTITY_EPS:   cfg.identity_eps   <= cfg_data;
        CFG_DEGENERATE_EPS: cfg.degenerate_eps <= cfg_data;
        CFG_SINGULAR_EPS:   cfg.singular_eps   <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: classification and numerators
  logic                 f_vld;
  side_t                f_side;
  num_t [NUM_DIV-1:0]   f_num;
  den_t                 f_den;

  chp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (quad_valid),
    .quad    (quad),
    .cfg     (cfg),
    .out_vld (f_vld),
    .side    (f_side),
    .num     (f_num),
    .den     (f_den)
  );

  // six dividers share the denominator
  coord_t quo [NUM_DIV];

  for (genvar i = 0; i < NUM_DIV; i++) begin : g_div
    chp_divider u_div (
      .clk (clk),
      .en  (en),
      .num (f_num[i]),
      .den (f_den),
      .quo (quo[i])
    );
  end

  // status and affine results ride alongside the dividers
  logic [DIV_LAT-1:0] sb_vld;
  side_t              sb [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_vld <= '0;
    end else if (en) begin
      sb_vld <= {sb_vld[DIV_LAT-2:0], f_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= f_side;
      for (int k = 1; k < DIV_LAT; k++) begin
        sb[k] <= sb[k-1];
      end
    end
  end

  // result select: zeros on reject, corner differences when affine
  side_t tail;
  map_t  map_next;

  assign tail = sb[DIV_LAT-1];

  always_comb begin
    map_next        = '0;
    map_next.status = tail.status;
    if (tail.status == ST_OK) begin
      map_next.coef_c = tail.c;
      map_next.coef_f = tail.f;
      if (tail.affine) begin
        map_next.coef_a = tail.a;
        map_next.coef_b = tail.b;
        map_next.coef_d = tail.d;
        map_next.coef_e = tail.e;
      end else begin
        map_next.coef_a = quo[DIV_A];
        map_next.coef_b = quo[DIV_B];
        map_next.coef_d = quo[DIV_D];
        map_next.coef_e = quo[DIV_E];
        map_next.coef_g = quo[DIV_G];
        map_next.coef_h = quo[DIV_H];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid <= 1'b0;
    end else if (en) begin
      map_valid <= sb_vld[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      map <= map_next;
    end
  end

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the corner-pin homography unit
// Drives quads through a valid/ready driver with random idling, predicts the
// coefficients and status of each accepted quad in 128-bit integers, and
// compares every map item field by field against the oldest prediction.
// Runs several tolerance settings, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
  import chp_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam longint Q = 65536;
  localparam longint IDENT_PT [8] = '{0, 0, Q, 0, Q, Q, 0, Q};

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          quad_valid = 1'b0;
  logic          quad_ready;
  quad_t         quad = '0;
  logic          map_valid;
  logic          map_ready = 1'b0;
  map_t          map;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [EW-1:0] cfg_data = '0;

  corner_pin_homography_unit uut (
    .clk(clk), .rst(rst),
    .quad_valid(quad_valid), .quad_ready(quad_ready), .quad(quad),
    .map_valid(map_valid), .map_ready(map_ready), .map(map),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the tolerance registers
  longint ident_tol = 1;
  longint degen_tol = 4;
  longint sing_tol  = 1;

  quad_t  pending_quads[$];
  map_t   expected_maps[$];
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     errors = 0;
  int     maps_seen = 0;
  int     status_count[4] = '{0, 0, 0, 0};

  // ---------------------------------------------------------------------------
  // predictor: exact integer arithmetic, 128 bits is ample for every term
  // ---------------------------------------------------------------------------
  function automatic wide_t wmul(wide_t a, wide_t b);
    return a * b;
  endfunction

  function automatic bit below(wide_t a, longint tol);
    wide_t m;
    m = (a < 0) ? -a : a;
    return m < wide_t'(tol);
  endfunction

  function automatic int sign_of(wide_t a);
    return (a < 0) ? -1 : ((a == 0) ? 0 : 1);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // nearest, ties away from zero, then saturated to 32 bits
  function automatic longint div_round_sat(wide_t n, wide_t d);
    bit neg;
    logic [127:0] un, ud, qq, rr;
    neg = (n < 0) != (d < 0);
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    qq = un / ud;
    rr = un % ud;
    if ((rr << 1) >= ud) qq = qq + 1;
    if (neg) begin
      if (qq > 128'd2147483648) return -64'sd2147483648;
      return -longint'(qq[63:0]);
    end
    if (qq > 128'd2147483647) return 64'sd2147483647;
    return longint'(qq[63:0]);
  endfunction

  function automatic bit is_convex(longint p[8]);
    wide_t s, cr;
    int sg, si, j, b, c;
    s = 0;
    sg = 0;
    for (int i = 0; i < 4; i++) begin
      j = (i + 1) % 4;
      s = s + wmul(p[2*i], p[2*j+1]) - wmul(p[2*j], p[2*i+1]);
    end
    if (below(s, 2 * degen_tol)) return 1'b0;
    for (int i = 0; i < 4; i++) begin
      b = (i + 1) % 4;
      c = (i + 2) % 4;
      cr = wmul(p[2*b] - p[2*i], p[2*c+1] - p[2*b+1])
         - wmul(p[2*b+1] - p[2*i+1], p[2*c] - p[2*b]);
      if (below(cr, degen_tol)) return 1'b0;
      si = sign_of(cr);
      if (sg == 0) sg = si;
      else if (si != sg) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic map_t predict_map(quad_t q);
    longint p[8], co[8];
    longint dx1, dx2, dx3, dy1, dy2, dy3, diff;
    wide_t den, ng, nh;
    status_t st;
    bit ident;
    map_t m;
    p = '{q.corner0_x, q.corner0_y, q.corner1_x, q.corner1_y,
          q.corner2_x, q.corner2_y, q.corner3_x, q.corner3_y};
    co = '{0, 0, 0, 0, 0, 0, 0, 0};
    ident = 1'b1;
    for (int i = 0; i < 8; i++) begin
      diff = p[i] - IDENT_PT[i];
      if (diff < 0) diff = -diff;
      if (diff > ident_tol) ident = 1'b0;
    end
    st = ST_OK;
    if (ident) st = ST_IDENT;
    else if (!is_convex(p)) st = ST_DEGEN;
    else begin
      dx1 = p[2] - p[4];  dx2 = p[6] - p[4];  dx3 = p[0] - p[2] + p[4] - p[6];
      dy1 = p[3] - p[5];  dy2 = p[7] - p[5];  dy3 = p[1] - p[3] + p[5] - p[7];
      if (below(wide_t'(dx3) * 65536, sing_tol) && below(wide_t'(dy3) * 65536, sing_tol)) begin
        // affine: parallelogram within tolerance
        co = '{sat32(p[2] - p[0]), sat32(p[4] - p[2]), p[0],
               sat32(p[3] - p[1]), sat32(p[5] - p[3]), p[1], 0, 0};
      end else begin
        den = wmul(dx1, dy2) - wmul(dx2, dy1);
        if (den == 0 || below(den, sing_tol)) st = ST_SINGULAR;
        else begin
          ng = wmul(dx3, dy2) - wmul(dx2, dy3);
          nh = wmul(dx1, dy3) - wmul(dx3, dy1);
          co[6] = div_round_sat(ng * 65536, den);
          co[7] = div_round_sat(nh * 65536, den);
          co[0] = div_round_sat(wmul(p[2] - p[0], den) + ng * wide_t'(p[2]), den);
          co[1] = div_round_sat(wmul(p[6] - p[0], den) + nh * wide_t'(p[6]), den);
          co[3] = div_round_sat(wmul(p[3] - p[1], den) + ng * wide_t'(p[3]), den);
          co[4] = div_round_sat(wmul(p[7] - p[1], den) + nh * wide_t'(p[7]), den);
          co[2] = p[0];
          co[5] = p[1];
        end
      end
    end
    if (st != ST_OK) co = '{0, 0, 0, 0, 0, 0, 0, 0};
    m.coef_a = co[0][31:0];  m.coef_b = co[1][31:0];  m.coef_c = co[2][31:0];
    m.coef_d = co[3][31:0];  m.coef_e = co[4][31:0];  m.coef_f = co[5][31:0];
    m.coef_g = co[6][31:0];  m.coef_h = co[7][31:0];
    m.status = st;
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic quad_t mkq(longint x0, y0, x1, y1, x2, y2, x3, y3);
    quad_t q;
    q.corner0_x = x0[31:0]; q.corner0_y = y0[31:0];
    q.corner1_x = x1[31:0]; q.corner1_y = y1[31:0];
    q.corner2_x = x2[31:0]; q.corner2_y = y2[31:0];
    q.corner3_x = x3[31:0]; q.corner3_y = y3[31:0];
    return q;
  endfunction

  function automatic longint srand(longint lim);
    return longint'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // random quad; mostly convex corner pins, some parallelograms, some noise
  function automatic quad_t random_quad();
    longint span, cx, cy, jit, x[4], y[4];
    int kind;
    quad_t q;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return q;
    end
    if (kind < 17) begin
      // near the identity square
      return mkq(srand(3), srand(3), Q + srand(3), srand(3),
                 Q + srand(3), Q + srand(3), srand(3), Q + srand(3));
    end
    span = ($urandom_range(0, 19) == 0) ? longint'($urandom_range(1 << 24, 1 << 29))
                                        : longint'($urandom_range(16, 1 << 20));
    cx = srand((1 << 30) - span);
    cy = srand((1 << 30) - span);
    jit = span / 3;
    x[0] = cx - span + srand(jit); y[0] = cy - span + srand(jit);
    x[1] = cx + span + srand(jit); y[1] = cy - span + srand(jit);
    x[2] = cx + span + srand(jit); y[2] = cy + span + srand(jit);
    x[3] = cx - span + srand(jit); y[3] = cy + span + srand(jit);
    if (kind < 30) begin
      // parallelogram: second differences vanish
      x[3] = x[0] + x[2] - x[1];
      y[3] = y[0] + y[2] - y[1];
    end else if (kind < 36) begin
      // dent one corner inward, or collapse it onto a neighbor
      x[2] = (kind < 33) ? cx : x[1];
      y[2] = (kind < 33) ? cy : y[1];
    end
    if ($urandom_range(0, 1))
      return mkq(x[0], y[0], x[3], y[3], x[2], y[2], x[1], y[1]);
    return mkq(x[0], y[0], x[1], y[1], x[2], y[2], x[3], y[3]);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: holds valid and payload until accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      quad_valid <= 1'b0;
    end else if (!quad_valid || quad_ready) begin
      if (pending_quads.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        quad <= pending_quads.pop_front();
        quad_valid <= 1'b1;
      end else begin
        quad_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) begin
      map_ready <= 1'b0;
    end else begin
      map_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // register mirror and prediction of each accepted quad
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDENTITY_EPS:   ident_tol = cfg_data;
        CFG_DEGENERATE_EPS: degen_tol = cfg_data;
        CFG_SINGULAR_EPS:   sing_tol  = cfg_data;
        default: ;
      endcase
    end
    if (!rst && quad_valid && quad_ready)
      expected_maps.push_back(predict_map(quad));
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
    end
  endtask

  // monitor: compare against the oldest prediction
  always @(posedge clk) begin
    map_t e;
    if (!rst && map_valid && map_ready) begin
      if (expected_maps.size() == 0) begin
        errors++;
        $display("%0t: map item with nothing expected, got %h", $time, map);
      end else begin
        e = expected_maps.pop_front();
        maps_seen++;
        status_count[e.status]++;
        check_field("coef_a", e.coef_a, map.coef_a);
        check_field("coef_b", e.coef_b, map.coef_b);
        check_field("coef_c", e.coef_c, map.coef_c);
        check_field("coef_d", e.coef_d, map.coef_d);
        check_field("coef_e", e.coef_e, map.coef_e);
        check_field("coef_f", e.coef_f, map.coef_f);
        check_field("coef_g", e.coef_g, map.coef_g);
        check_field("coef_h", e.coef_h, map.coef_h);
        check_field("status", 32'(e.status), 32'(map.status));
      end
    end
  end

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [EW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_quads.size() != 0 || quad_valid || expected_maps.size() != 0);
    repeat (50) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    longint mx, mn;
    int idle_mode;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin
          write_reg(CFG_IDENTITY_EPS, 16'd0);
          write_reg(CFG_DEGENERATE_EPS, 16'd0);
          write_reg(CFG_SINGULAR_EPS, 16'd0);
        end
        2: begin
          write_reg(CFG_IDENTITY_EPS, 16'hFFFF);
          write_reg(CFG_DEGENERATE_EPS, 16'hFFFF);
          write_reg(CFG_SINGULAR_EPS, 16'hFFFF);
        end
        3: begin
          write_reg(CFG_IDENTITY_EPS, 16'($urandom));
          write_reg(CFG_DEGENERATE_EPS, 16'($urandom));
          write_reg(CFG_SINGULAR_EPS, 16'($urandom));
        end
        4: begin
          write_reg(CFG_IDENTITY_EPS, 16'd3);
          write_reg(CFG_DEGENERATE_EPS, 16'd4);
          write_reg(CFG_SINGULAR_EPS, 16'd1);
          write_reg(2'd3, 16'hFFFF);   // unmapped index, must be dropped
        end
        5: begin
          write_reg(CFG_IDENTITY_EPS, 16'd1);
          write_reg(CFG_SINGULAR_EPS, 16'd0);
        end
        default: ;
      endcase

      if (ph == 0) begin
        pending_quads.push_back(mkq(0, 0, Q, 0, Q, Q, 0, Q));               // identity
        pending_quads.push_back(mkq(1, -1, Q + 1, 1, Q - 1, Q, -1, Q + 1)); // within tolerance
        pending_quads.push_back(mkq(2, 0, Q, 0, Q, Q, 0, Q));               // just outside
        pending_quads.push_back(mkq(0, 0, 0, 0, 0, 0, 0, 0));
        pending_quads.push_back(mkq(mx, mx, mx, mx, mx, mx, mx, mx));
        pending_quads.push_back(mkq(mn, mn, mn, mn, mn, mn, mn, mn));
        pending_quads.push_back(mkq(mn, mn, mx, mn, mx, mx, mn, mx));       // saturating affine
        pending_quads.push_back(mkq(mn, mn, mx, mn, mx, mx, mn, mx - Q));   // saturating projective
        pending_quads.push_back(mkq(0, 0, 2*Q, 0, 2*Q, 2*Q, 0, 2*Q));       // affine
        pending_quads.push_back(mkq(0, 0, 3*Q, Q/2, 2*Q, 2*Q, -Q/4, 3*Q));  // projective
        pending_quads.push_back(mkq(0, 0, 0, 2*Q, 2*Q, 2*Q, 2*Q, 0));       // clockwise
        pending_quads.push_back(mkq(0, 0, 4*Q, 0, Q, Q, 0, 4*Q));           // concave
        pending_quads.push_back(mkq(0, 0, Q, Q, 2*Q, 2*Q, 3*Q, 3*Q));       // collinear
        pending_quads.push_back(mkq(0, 0, 2*Q, 0, 0, 2*Q, 2*Q, 2*Q));       // bow tie
        pending_quads.push_back(mkq(0, 0, 1, 0, 1, 1, 0, 1));               // tiny area
        pending_quads.push_back(mkq(0, 0, 3, 0, 3, 3, 0, 3));               // small, over threshold
      end
      if (ph == 1) begin
        // zero cross on the first corner is accepted, after a nonzero one it is not
        pending_quads.push_back(mkq(0, 0, Q, 0, 2*Q, 0, Q, 2*Q));
        pending_quads.push_back(mkq(0, 0, 2*Q, 0, 2*Q, 2*Q, Q, Q));
        // parallelogram takes the projective path when the singular tolerance is zero
        pending_quads.push_back(mkq(0, 0, 2*Q, 0, 3*Q, 2*Q, Q, 2*Q));
        pending_quads.push_back(mkq(0, 0, Q, 0, Q, Q, 0, Q));               // exact identity only
        pending_quads.push_back(mkq(1, 0, Q, 0, Q, Q, 0, Q));
      end

      for (int i = 0; i < 320; i++) pending_quads.push_back(random_quad());

      // idling by phase: none with one heavy segment of both, sender idle, receiver stall, both
      idle_mode = ph % 4;
      for (int s = 0; s < 4; s++) begin
        send_idle_pct  = (s == 0) ? 0 : ((idle_mode == 1) ? 64 : (idle_mode == 3) ? 18 : 0);
        recv_stall_pct = (s == 0) ? 0 : ((idle_mode == 2) ? 64 : (idle_mode == 3) ? 18 : 0);
        if (idle_mode == 0 && s == 2) begin
          send_idle_pct = 64;
          recv_stall_pct = 64;
        end
        repeat ($urandom_range(100, 400)) @(posedge clk);
      end
      wait_drained();
    end

    $display("tb_top: %0d maps checked over 6 tolerance settings", maps_seen);
    $display("tb_top: ok %0d, identity %0d, rejected %0d, singular %0d",
             status_count[0], status_count[1], status_count[2], status_count[3]);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_top: timeout");
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
